// File: hdl/bsfs_pkg.sv
// ----------------------------------------------------------------------------
// bsfs_pkg
// shared types, constants and helpers for the backend selection block
// ----------------------------------------------------------------------------
package bsfs_pkg;

  localparam int MaxNodes   = 16;
  localparam int NodeW      = $clog2(MaxNodes);
  localparam int CntW       = NodeW + 1;
  localparam int TimeW      = 32;
  localparam int ScoreW     = 5;
  localparam int KeyW       = 64;
  localparam int DigitW     = 4;
  localparam int DivSteps   = KeyW / DigitW;
  localparam int DivCntW    = $clog2(DivSteps + 1);

  localparam logic [ScoreW-1:0] ScoreLimit   = 5'd20;
  localparam logic [ScoreW-1:0] FailStep     = 5'd2;
  localparam logic [ScoreW-1:0] SuccessStep  = 5'd1;
  localparam logic [TimeW-1:0]  RetrySeconds = 32'd10;

  typedef enum logic [1:0] {
    OpSelect  = 2'd0,
    OpNext    = 2'd1,
    OpSuccess = 2'd2,
    OpFail    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoNodes  = 2'd1,
    StKeptOld  = 2'd2,
    StFallback = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ModeRandom = 2'd0,
    ModeAddr   = 2'd1,
    ModeCookie = 2'd2,
    ModeSpare  = 2'd3
  } mode_e;

  localparam logic RegNodeCount   = 1'b0;
  localparam logic RegBalanceMode = 1'b1;

  typedef struct packed {
    opcode_e           op;
    logic [NodeW-1:0]  key_rem;
    logic [NodeW-1:0]  ip_rem;
    logic [NodeW-1:0]  rnd_rem;
    logic [TimeW-1:0]  now;
  } item_t;

  // one restoring step of a remainder over one digit, r < n on entry
  function automatic logic [CntW-1:0] mod_digit(logic [CntW-1:0] r,
                                                logic [DigitW-1:0] d,
                                                logic [CntW-1:0] n);
    logic [CntW-1:0] t;
    t = r;
    for (int b = DigitW - 1; b >= 0; b--) begin
      t = {t[CntW-2:0], d[b]};
      if (t >= n) begin
        t = t - n;
      end
    end
    return t;
  endfunction

endpackage

// File: hdl/bsfs_front.sv
// ----------------------------------------------------------------------------
// bsfs_front
// accepts requests, picks the key and reduces key, address and random value
// modulo the node count one digit per cycle
// ----------------------------------------------------------------------------
module bsfs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  opcode_i,
  input  logic [31:0]                 client_ip_i,
  input  logic [63:0]                 cookie_hash_i,
  input  logic                        cookie_present_i,
  input  logic [30:0]                 random_value_i,
  input  logic [31:0]                 now_seconds_i,
  input  logic [bsfs_pkg::CntW-1:0]   n_i,
  input  logic [1:0]                  mode_i,
  output logic                        q_push_o,
  input  logic                        q_full_i,
  output bsfs_pkg::item_t             q_item_o
);

  typedef enum logic [1:0] {
    FIdle,
    FDiv,
    FPush
  } fstate_e;

  fstate_e                        state_q;
  logic [bsfs_pkg::KeyW-1:0]      key_q, ip_q, rnd_q;
  logic [bsfs_pkg::CntW-1:0]      key_r_q, ip_r_q, rnd_r_q;
  logic [bsfs_pkg::DivCntW-1:0]   cnt_q;
  logic [1:0]                     op_q;
  logic [31:0]                    now_q;
  logic [bsfs_pkg::KeyW-1:0]      key_sel;
  localparam int Top = bsfs_pkg::KeyW - bsfs_pkg::DigitW;

  always_comb begin
    if (mode_i == bsfs_pkg::ModeRandom) begin
      key_sel = {33'd0, random_value_i};
    end else if (mode_i == bsfs_pkg::ModeCookie && cookie_present_i) begin
      key_sel = cookie_hash_i;
    end else begin
      key_sel = {32'd0, client_ip_i};
    end
  end

  assign full     = (state_q != FIdle);
  assign q_push_o = (state_q == FPush) && !q_full_i;
  assign q_item_o = '{op: bsfs_pkg::opcode_e'(op_q),
                      key_rem: key_r_q[bsfs_pkg::NodeW-1:0],
                      ip_rem: ip_r_q[bsfs_pkg::NodeW-1:0],
                      rnd_rem: rnd_r_q[bsfs_pkg::NodeW-1:0],
                      now: now_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        FIdle: begin
          if (push) begin
            key_q   <= key_sel;
            ip_q    <= {32'd0, client_ip_i};
            rnd_q   <= {33'd0, random_value_i};
            key_r_q <= '0;
            ip_r_q  <= '0;
            rnd_r_q <= '0;
            op_q    <= opcode_i;
            now_q   <= now_seconds_i;
            cnt_q   <= '0;
            state_q <= FDiv;
          end
        end
        FDiv: begin
          key_r_q <= bsfs_pkg::mod_digit(key_r_q, key_q[bsfs_pkg::KeyW-1:Top], n_i);
          ip_r_q  <= bsfs_pkg::mod_digit(ip_r_q, ip_q[bsfs_pkg::KeyW-1:Top], n_i);
          rnd_r_q <= bsfs_pkg::mod_digit(rnd_r_q, rnd_q[bsfs_pkg::KeyW-1:Top], n_i);
          key_q   <= key_q << bsfs_pkg::DigitW;
          ip_q    <= ip_q << bsfs_pkg::DigitW;
          rnd_q   <= rnd_q << bsfs_pkg::DigitW;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == bsfs_pkg::DivCntW'(bsfs_pkg::DivSteps - 1)) begin
            state_q <= FPush;
          end
        end
        FPush: begin
          if (!q_full_i) begin
            state_q <= FIdle;
          end
        end
        default: state_q <= FIdle;
      endcase
    end
  end

endmodule

// File: hdl/bsfs_queue.sv
// ----------------------------------------------------------------------------
// bsfs_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module bsfs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bsfs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bsfs_pkg::item_t item_o
);

  bsfs_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: hdl/bsfs_back.sv
// ----------------------------------------------------------------------------
// bsfs_back
// carries out requests: score updates and a cyclic scan one node per cycle
// ----------------------------------------------------------------------------
module bsfs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bsfs_pkg::CntW-1:0]   n_i,
  input  logic                        q_valid_i,
  input  bsfs_pkg::item_t             q_item_i,
  output logic                        q_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [3:0]                  node_index_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  retry_count_o
);

  typedef enum logic [2:0] {
    BIdle,
    BDispatch,
    BMod,
    BScan,
    BOut
  } bstate_e;

  localparam int NodeW = bsfs_pkg::NodeW;
  localparam int CntW  = bsfs_pkg::CntW;

  bstate_e                       state_q;
  bsfs_pkg::item_t               it_q;
  logic [bsfs_pkg::ScoreW-1:0]   score_q [bsfs_pkg::MaxNodes];
  logic [31:0]                   time_q  [bsfs_pkg::MaxNodes];
  logic [NodeW-1:0]              cur_q, k_q, i_q;
  logic [7:0]                    retry_q;
  logic [1:0]                    st_q;
  logic [CntW:0]                 sum_q;
  logic                          out_valid_q;
  logic [3:0]                    out_node_q;
  logic [1:0]                    out_st_q;
  logic [7:0]                    out_retry_q;

  logic [NodeW-1:0]              rd_idx;
  logic [bsfs_pkg::ScoreW-1:0]   rd_score, chg_score;
  logic [31:0]                   rd_time;
  logic                          cur_live, usable, out_free;
  logic [NodeW-1:0]              n_last;

  assign rd_idx   = (state_q == BScan) ? k_q : cur_q;
  assign rd_score = score_q[rd_idx];
  assign rd_time  = time_q[rd_idx];
  assign cur_live = ({1'b0, cur_q} < n_i);
  assign chg_score = rd_score + bsfs_pkg::FailStep;
  assign usable   = (rd_score < bsfs_pkg::ScoreLimit) ||
                    ((it_q.now - rd_time) >= bsfs_pkg::RetrySeconds);
  assign n_last   = NodeW'(n_i - 1'b1);
  assign out_free = !out_valid_q || pop;
  assign q_pop_o  = (state_q == BIdle) && q_valid_i;

  assign empty         = !out_valid_q;
  assign node_index_o  = out_node_q;
  assign status_o      = out_st_q;
  assign retry_count_o = out_retry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      cur_q       <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      st_q        <= bsfs_pkg::StOk;
      sum_q       <= '0;
      for (int j = 0; j < bsfs_pkg::MaxNodes; j++) begin
        score_q[j] <= '0;
        time_q[j]  <= '0;
      end
    end else begin
      // a new beat loaded in BOut replaces the one being popped
      if (pop && (state_q != BOut)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BIdle: begin
          if (q_valid_i) begin
            it_q    <= q_item_i;
            state_q <= BDispatch;
          end
        end
        BDispatch: begin
          if (n_i == '0) begin
            st_q    <= bsfs_pkg::StNoNodes;
            state_q <= BOut;
          end else begin
            case (it_q.op)
              bsfs_pkg::OpSuccess: begin
                if (cur_live) begin
                  score_q[cur_q] <= (rd_score > bsfs_pkg::SuccessStep) ?
                                    rd_score - bsfs_pkg::SuccessStep : '0;
                end
                st_q    <= bsfs_pkg::StOk;
                state_q <= BOut;
              end
              bsfs_pkg::OpSelect: begin
                k_q     <= it_q.key_rem;
                i_q     <= '0;
                state_q <= BScan;
              end
              default: begin
                // failure charge, also the first half of next
                if (cur_live) begin
                  if (chg_score >= bsfs_pkg::ScoreLimit) begin
                    score_q[cur_q] <= bsfs_pkg::ScoreLimit;
                    time_q[cur_q]  <= it_q.now;
                  end else begin
                    score_q[cur_q] <= chg_score;
                  end
                end
                if ((it_q.op == bsfs_pkg::OpNext) && (n_i != CntW'(1))) begin
                  sum_q   <= (CntW + 1)'(cur_q) + (CntW + 1)'(it_q.ip_rem);
                  state_q <= BMod;
                end else begin
                  st_q    <= (it_q.op == bsfs_pkg::OpNext) ? bsfs_pkg::StKeptOld :
                                                             bsfs_pkg::StOk;
                  state_q <= BOut;
                end
              end
            endcase
          end
        end
        BMod: begin
          // a stale current node may need several subtractions
          if (sum_q >= {1'b0, n_i}) begin
            sum_q <= sum_q - {1'b0, n_i};
          end else begin
            k_q     <= sum_q[NodeW-1:0];
            i_q     <= '0;
            state_q <= BScan;
          end
        end
        BScan: begin
          if (usable) begin
            if (rd_score >= bsfs_pkg::ScoreLimit) begin
              time_q[k_q] <= it_q.now;
            end
            cur_q   <= k_q;
            st_q    <= bsfs_pkg::StOk;
            state_q <= BOut;
            if (it_q.op == bsfs_pkg::OpSelect) begin
              retry_q <= '0;
            end else if (retry_q != 8'hff) begin
              retry_q <= retry_q + 1'b1;
            end
          end else if (i_q == n_last) begin
            state_q <= BOut;
            if (it_q.op == bsfs_pkg::OpSelect) begin
              cur_q   <= it_q.rnd_rem;
              retry_q <= '0;
              st_q    <= bsfs_pkg::StFallback;
            end else begin
              st_q <= bsfs_pkg::StKeptOld;
            end
          end else begin
            i_q <= i_q + 1'b1;
            k_q <= (k_q == n_last) ? '0 : k_q + 1'b1;
          end
        end
        BOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_node_q  <= cur_q;
            out_st_q    <= st_q;
            out_retry_q <= retry_q;
            state_q     <= BIdle;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

endmodule

// File: hdl/backend_select_with_fail_scoring.sv
// ----------------------------------------------------------------------------
// backend_select_with_fail_scoring
// health-scored backend node selection for one request group
//
//  channel   handshake           beat
//  request   push / full         opcode, client_ip, cookie_hash,
//                                cookie_present, random_value, now_seconds
//  result    empty / pop         node_index, status, retry_count
//  config    cfg_we_i            cfg_idx_i, cfg_data_i
//
// the front reduces the key modulo the count, 4 bits a cycle
// the back handles reports in its dispatch state and scans one node per cycle for
// select and next; next first reduces its scan start by repeated subtraction
// the queue lets the front reduce the next request while the back scans
// reset clears all scores and times at once; once the queue fills, a held result blocks the front as well as the back
// ----------------------------------------------------------------------------
module backend_select_with_fail_scoring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] client_ip_i,
  input  logic [63:0] cookie_hash_i,
  input  logic        cookie_present_i,
  input  logic [30:0] random_value_i,
  input  logic [31:0] now_seconds_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  node_index_o,
  output logic [1:0]  status_o,
  output logic [7:0]  retry_count_o
);

  logic [4:0]                    node_count_q;
  logic [1:0]                    balance_mode_q;
  logic [bsfs_pkg::CntW-1:0]     n_eff;
  logic                          q_push, q_full, q_pop, q_valid;
  bsfs_pkg::item_t               q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= 5'd0;
      balance_mode_q <= bsfs_pkg::ModeAddr;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bsfs_pkg::RegNodeCount) begin
        node_count_q <= cfg_data_i;
      end else begin
        balance_mode_q <= cfg_data_i[1:0];
      end
    end
  end

  assign n_eff = (node_count_q > 5'(bsfs_pkg::MaxNodes)) ?
                 bsfs_pkg::CntW'(bsfs_pkg::MaxNodes) : node_count_q;

  bsfs_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .opcode_i, .client_ip_i, .cookie_hash_i, .cookie_present_i,
    .random_value_i, .now_seconds_i,
    .n_i(n_eff), .mode_i(balance_mode_q),
    .q_push_o(q_push), .q_full_i(q_full), .q_item_o(q_in)
  );

  bsfs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .item_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .item_o(q_out)
  );

  bsfs_back u_back (
    .clk_i, .rst_ni, .n_i(n_eff),
    .q_valid_i(q_valid), .q_item_i(q_out), .q_pop_o(q_pop),
    .empty, .pop, .node_index_o, .status_o, .retry_count_o
  );

endmodule

// File: tb/bsfs_checker.sv
// ----------------------------------------------------------------------------
// bsfs_checker
// predicts backend selection results from accepted requests and config writes
// and compares every popped result beat against the oldest prediction
// ----------------------------------------------------------------------------
module bsfs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] client_ip_i,
  input  logic [63:0] cookie_hash_i,
  input  logic        cookie_present_i,
  input  logic [30:0] random_value_i,
  input  logic [31:0] now_seconds_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  node_index_o,
  input  logic [1:0]  status_o,
  input  logic [7:0]  retry_count_o,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]        node;
    bsfs_pkg::status_e st;
    logic [7:0]        retries;
  } choice_t;

  logic [4:0]                  cnt_q;
  bsfs_pkg::mode_e             mode_q;
  logic [bsfs_pkg::ScoreW-1:0] score_q [bsfs_pkg::MaxNodes];
  logic [31:0]                 ftime_q [bsfs_pkg::MaxNodes];
  logic [3:0]                  cur_q;
  logic [7:0]                  retry_q;
  choice_t                     choices_q[$];
  int                          fails;

  assign fail_cnt_o = fails;
  assign pending_o  = choices_q.size();

  // first usable node in cyclic order from start; refreshes a stale-failed one
  function automatic bit find_usable(int start, int n, logic [31:0] now, output int pick);
    int k;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      k = (start + i) % n;
      if (score_q[k] < bsfs_pkg::ScoreLimit) begin
        pick = k;
        return 1;
      end
      if (32'(now - ftime_q[k]) >= bsfs_pkg::RetrySeconds) begin
        ftime_q[k] = now;
        pick = k;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void charge(int n, logic [31:0] now);
    int s;
    if (cur_q >= n) return;
    s = score_q[cur_q] + bsfs_pkg::FailStep;
    if (s >= bsfs_pkg::ScoreLimit) begin
      s = bsfs_pkg::ScoreLimit;
      ftime_q[cur_q] = now;
    end
    score_q[cur_q] = bsfs_pkg::ScoreW'(s);
  endfunction

  function automatic choice_t route_request(bsfs_pkg::opcode_e op, logic [31:0] ip,
                                            logic [63:0] ck, logic has_ck,
                                            logic [30:0] rnd, logic [31:0] now);
    int      n;
    int      pick;
    choice_t c;
    logic [63:0] key;
    n = (cnt_q > bsfs_pkg::MaxNodes) ? bsfs_pkg::MaxNodes : int'(cnt_q);
    c.st = bsfs_pkg::StOk;
    if (n == 0) begin
      c.st = bsfs_pkg::StNoNodes;
    end else if (op == bsfs_pkg::OpSelect) begin
      if (mode_q == bsfs_pkg::ModeRandom) key = 64'(rnd);
      else if (mode_q == bsfs_pkg::ModeCookie && has_ck) key = ck;
      else key = 64'(ip);
      if (!find_usable(int'(key % n), n, now, pick)) begin
        pick = int'(rnd % n);
        c.st = bsfs_pkg::StFallback;
      end
      cur_q = 4'(pick);
      retry_q = '0;
    end else if (op == bsfs_pkg::OpNext) begin
      charge(n, now);
      if (n == 1) begin
        c.st = bsfs_pkg::StKeptOld;
      end else if (find_usable(int'((cur_q + ip % n) % n), n, now, pick)) begin
        cur_q = 4'(pick);
        if (retry_q != 8'hff) retry_q++;
      end else begin
        c.st = bsfs_pkg::StKeptOld;
      end
    end else if (op == bsfs_pkg::OpSuccess) begin
      if (cur_q < n && score_q[cur_q] != 0) score_q[cur_q]--;
    end else begin
      charge(n, now);
    end
    c.node = cur_q;
    c.retries = retry_q;
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    choice_t want;
    if (!rst_ni) begin
      cnt_q   <= '0;
      mode_q  <= bsfs_pkg::ModeAddr;
      cur_q   = '0;
      retry_q = '0;
      fails   <= 0;
      for (int i = 0; i < bsfs_pkg::MaxNodes; i++) begin
        score_q[i] = '0;
        ftime_q[i] = '0;
      end
      choices_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bsfs_pkg::RegNodeCount) cnt_q <= cfg_data_i;
        else mode_q <= bsfs_pkg::mode_e'(cfg_data_i[1:0]);
      end
      if (push && !full) begin
        choices_q.push_back(route_request(bsfs_pkg::opcode_e'(opcode_i), client_ip_i,
                                          cookie_hash_i, cookie_present_i,
                                          random_value_i, now_seconds_i));
      end
      if (pop && !empty) begin
        if (choices_q.size() == 0) begin
          $display("%t unexpected result beat node=%0d status=%0d retries=%0d",
                   $time, node_index_o, status_o, retry_count_o);
          fails <= fails + 1;
        end else begin
          want = choices_q.pop_front();
          if (want.node !== node_index_o || want.st !== status_o
              || want.retries !== retry_count_o) begin
            $display("%t mismatch exp node=%0d status=%0d retries=%0d got %0d/%0d/%0d",
                     $time, want.node, want.st, want.retries,
                     node_index_o, status_o, retry_count_o);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_backend_select_with_fail_scoring.sv
// ----------------------------------------------------------------------------
// tb_backend_select_with_fail_scoring
// drives directed and random requests across node counts and balance modes
// with varied idling and a long result hold-off; the checker judges results
// ----------------------------------------------------------------------------
module tb_backend_select_with_fail_scoring;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_idx_i;
  logic [4:0]  cfg_data_i;
  logic        push, full, empty, pop;
  logic [1:0]  opcode_i;
  logic [31:0] client_ip_i, now_seconds_i;
  logic [63:0] cookie_hash_i;
  logic        cookie_present_i;
  logic [30:0] random_value_i;
  logic [3:0]  node_index_o;
  logic [1:0]  status_o;
  logic [7:0]  retry_count_o;
  int          fail_cnt, pending;
  int          send_idle_pct, pop_stall_pct;
  bit          hold_off;
  longint      cycles;
  logic [31:0] clock_s;

  backend_select_with_fail_scoring u_dut (.*);
  bsfs_checker u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("tb_backend_select_with_fail_scoring NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int hold;
    pop = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 0;
        for (hold = 0; hold < 400; hold++) @(negedge clk_i);
        hold_off = 0;
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // one request beat; time mostly creeps forward so ages cross ten seconds
  task automatic offer(bsfs_pkg::opcode_e op, logic [31:0] ip, logic [63:0] ck,
                       logic has_ck, logic [30:0] rnd, logic [31:0] now);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk_i);
    end
    push <= 1;
    opcode_i <= op;
    client_ip_i <= ip;
    cookie_hash_i <= ck;
    cookie_present_i <= has_ck;
    random_value_i <= rnd;
    now_seconds_i <= now;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int r;
    bsfs_pkg::opcode_e op;
    r = $urandom_range(99);
    op = r < 30 ? bsfs_pkg::OpSelect : r < 55 ? bsfs_pkg::OpNext :
         r < 72 ? bsfs_pkg::OpSuccess : bsfs_pkg::OpFail;
    if ($urandom_range(19) == 0) clock_s = $urandom;
    else clock_s += 32'($urandom_range(3));
    offer(op, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)), 31'($urandom),
          clock_s);
  endtask

  initial begin
    int n_sel [8] = '{1, 2, 3, 16, 17, 31, 5, 0};
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    push = 0; opcode_i = 0; client_ip_i = 0; cookie_hash_i = 0;
    cookie_present_i = 0; random_value_i = 0; now_seconds_i = 0;
    send_idle_pct = 0; pop_stall_pct = 0; hold_off = 0; clock_s = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: no nodes first, then extremes with a few nodes
    offer(bsfs_pkg::OpSelect, '1, '1, 1'b1, '1, '1);
    offer(bsfs_pkg::OpNext, '0, '0, 1'b0, '0, '0);
    drain();
    write_reg(bsfs_pkg::RegNodeCount, 5'd1);
    offer(bsfs_pkg::OpNext, '0, '0, 1'b0, '0, '0);
    drain();
    write_reg(bsfs_pkg::RegNodeCount, 5'd4);
    write_reg(bsfs_pkg::RegBalanceMode, 5'(bsfs_pkg::ModeCookie));
    offer(bsfs_pkg::OpSelect, 32'h0, '1, 1'b1, 31'h0, 32'h0);
    offer(bsfs_pkg::OpSelect, '1, '1, 1'b0, '1, 32'h0);
    for (int i = 0; i < 12; i++) offer(bsfs_pkg::OpFail, '0, '0, 1'b0, '0, 32'd5);
    offer(bsfs_pkg::OpSuccess, '0, '0, 1'b0, '0, 32'd5);
    for (int i = 0; i < 4; i++) offer(bsfs_pkg::OpNext, 32'd1, '0, 1'b0, '0, 32'd6);
    offer(bsfs_pkg::OpSelect, 32'd2, '0, 1'b0, 31'd3, 32'd7);
    offer(bsfs_pkg::OpSelect, 32'd2, '0, 1'b0, 31'd3, 32'hffff_fffc);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 78; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 78; end
        default: begin send_idle_pct = 6; pop_stall_pct = 6; end
      endcase
      write_reg(bsfs_pkg::RegNodeCount, 5'(n_sel[ph % 8]));
      write_reg(bsfs_pkg::RegBalanceMode, 5'(ph % 4));
      if (ph == 4) hold_off = 1;
      for (int i = 0; i < 78; i++) random_item();
      drain();
    end

    pop_stall_pct = 0;
    drain();
    if (fail_cnt == 0) begin
      $display("tb_backend_select_with_fail_scoring OK");
    end else begin
      $display("tb_backend_select_with_fail_scoring NOT OK");
    end
    $finish;
  end

endmodule
